FILE: rtl/pur_pkg.sv
`timescale 1ns / 1ps

package pur_pkg;

  // Sizes of the stores
  localparam int RING_DEPTH   = 256;
  localparam int PALETTE_SIZE = 256;
  localparam int COLOR_BITS   = 24;

  localparam int RING_AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int PAL_AW  = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;

  // Record count saturates at the smaller of ring depth and 255
  localparam logic [7:0] LEN_CAP = 8'((RING_DEPTH < 255) ? RING_DEPTH : 255);

  // Tracked pen value that means no pen is tracked
  localparam logic [8:0] PEN_NONE = 9'h1FF;

  typedef logic [COLOR_BITS-1:0] color_t;

  typedef enum logic [2:0] {
    FN_WRITE = 3'd0,
    FN_READ  = 3'd1,
    FN_STORE = 3'd2,
    FN_PUSH  = 3'd3,
    FN_UNDO  = 3'd4
  } func_t;

  // One input beat, unpacked
  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  pen;
    logic [23:0] color;
    logic        use_given;
    logic        linked;
  } item_t;

  // One result beat
  typedef struct packed {
    logic [7:0]  restored;
    logic [7:0]  undo_count;
    logic [23:0] color_out;
    logic        notify;
  } result_t;

  // Palette memory port
  typedef struct packed {
    logic              re;
    logic [PAL_AW-1:0] raddr;
    logic              we;
    logic [PAL_AW-1:0] waddr;
    color_t            wdata;
  } pal_req_t;

  // One undo record
  typedef struct packed {
    logic [7:0] pen;
    color_t     color;
    logic       linked;
  } rec_t;

  // Record memory port
  typedef struct packed {
    logic               re;
    logic [RING_AW-1:0] raddr;
    logic               we;
    logic [RING_AW-1:0] waddr;
    rec_t               wrec;
  } ring_req_t;

endpackage

FILE: rtl/palette_undo_ring.sv
`timescale 1ns / 1ps

// Palette of 256 pens with a 256-record undo ring.
// Input channel s_*: one beat per command; s_tuser selects write colour,
// read colour, store-undo-if-needed, push undo or undo. Output channel m_*:
// exactly one result beat per command, in command order.
// Write, read, store and push pass from the accepted beat through the execute
// and done states to m_tvalid. Undo pops records from the ring: each is read
// from the record memory (a registered read), then written back to the palette;
// the walk goes on while popped records are linked and ends on an empty ring.
// s_tready is high again in the same cycle that m_tvalid rises.
// One command is in work at a time; s_tready is high only when the
// sequencer is free.
// Reset clears the palette (valid bits, so every pen reads zero at once),
// empties the ring and drops the tracked pen; no clearing pass is needed.
// When m_tready is low the result holds in the output register; the block
// still takes and works one more command, which then waits for the register.

module palette_undo_ring (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [7:0] pen, [31:8] color, [32] use_given_color, [33] linked, [39:34] zero
  input  logic [39:0] s_tdata,
  // [2:0] func
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] notify, [24:1] color_out, [32:25] undo_count, [40:33] restored,
  // [47:41] zero
  output logic [47:0] m_tdata
);

  pur_pkg::item_t     in_item;
  pur_pkg::result_t   res;
  pur_pkg::result_t   out_q;
  pur_pkg::pal_req_t  pal_req;
  pur_pkg::color_t    pal_rdata;
  pur_pkg::ring_req_t ring_req;
  pur_pkg::rec_t      ring_rdata;
  logic               res_valid;
  logic               out_free;

  assign in_item = '{func: s_tuser, pen: s_tdata[7:0], color: s_tdata[31:8],
                     use_given: s_tdata[32], linked: s_tdata[33]};

  pur_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .res_valid  (res_valid),
    .res_take   (out_free),
    .res        (res),
    .pal_req    (pal_req),
    .pal_rdata  (pal_rdata),
    .ring_req   (ring_req),
    .ring_rdata (ring_rdata)
  );

  pur_pal u_pal (
    .clk   (clk),
    .rst   (rst),
    .req   (pal_req),
    .rdata (pal_rdata)
  );

  pur_ring u_ring (
    .clk   (clk),
    .req   (ring_req),
    .rdata (ring_rdata)
  );

  // Output register: load when empty or being drained
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      out_q <= res;
    end
  end

  assign m_tdata = {7'd0, out_q.restored, out_q.undo_count, out_q.color_out, out_q.notify};

  // A finished result always reaches the output register
  a_res_loaded: assert property (@(posedge clk) disable iff (rst)
    res_valid && out_free |=> m_tvalid)
    else $error("finished result not loaded into output register");

  // Record memory is never read and written in one cycle
  a_ring_port: assert property (@(posedge clk) disable iff (rst)
    !(ring_req.re && ring_req.we))
    else $error("record memory read and write collide");

  // Record count stays within its cap
  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_q.undo_count <= pur_pkg::LEN_CAP)
    else $error("undo count above cap");

  // Any popped record comes from an undo, which always notifies
  a_pop_notify: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_q.restored != 8'd0) |-> out_q.notify)
    else $error("records restored without notify");

endmodule

FILE: rtl/pur_pal.sv
`timescale 1ns / 1ps

module pur_pal (
  input  logic              clk,
  input  logic              rst,
  input  pur_pkg::pal_req_t req,
  output pur_pkg::color_t   rdata
);

  pur_pkg::color_t                   mem [pur_pkg::PALETTE_SIZE];
  logic [pur_pkg::PALETTE_SIZE-1:0]  valid;
  pur_pkg::color_t                   rd_q;
  logic                              rv_q;
  logic                              fwd;

  assign fwd = req.we && (req.waddr == req.raddr);

  // Write the array and register the read word
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_q <= fwd ? req.wdata : mem[req.raddr];
    end
  end

  // Track written entries; unwritten ones read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rv_q  <= 1'b0;
    end else begin
      if (req.we) begin
        valid[req.waddr] <= 1'b1;
      end
      if (req.re) begin
        rv_q <= valid[req.raddr] | fwd;
      end
    end
  end

  assign rdata = rv_q ? rd_q : '0;

endmodule

FILE: rtl/pur_ring.sv
`timescale 1ns / 1ps

module pur_ring (
  input  logic               clk,
  input  pur_pkg::ring_req_t req,
  output pur_pkg::rec_t      rdata
);

  pur_pkg::rec_t mem [pur_pkg::RING_DEPTH];

  // Write a record, register the read record
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wrec;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

FILE: rtl/pur_ctrl.sv
`timescale 1ns / 1ps

module pur_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pur_pkg::item_t     in_item,
  output logic               res_valid,
  input  logic               res_take,
  output pur_pkg::result_t   res,
  output pur_pkg::pal_req_t  pal_req,
  input  pur_pkg::color_t    pal_rdata,
  output pur_pkg::ring_req_t ring_req,
  input  pur_pkg::rec_t      ring_rdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_UREQ,
    ST_UPOP,
    ST_DONE
  } state_t;

  state_t                       state;
  pur_pkg::func_t               op;
  logic [7:0]                   pen;
  logic [23:0]                  color;
  logic                         use_given;
  logic                         lk;
  logic [8:0]                   tracked_pen;
  pur_pkg::color_t              tracked_color;
  logic                         tracked_saved;
  logic [pur_pkg::RING_AW-1:0]  head;
  logic [7:0]                   length;
  logic [7:0]                   restored;
  pur_pkg::result_t             result;

  logic                         pen_ok;
  logic                         rec_pen_ok;
  pur_pkg::color_t              pdat;
  pur_pkg::color_t              color_m;
  logic [pur_pkg::RING_AW-1:0]  head_inc;
  logic [pur_pkg::RING_AW-1:0]  head_dec;
  logic [7:0]                   len_inc;
  logic                         same_pen;
  logic                         do_push;
  pur_pkg::rec_t                push_rec;
  pur_pkg::result_t             res_next;

  // Operand decode and ring pointer arithmetic
  always_comb begin
    pen_ok     = {1'b0, pen} < 9'(pur_pkg::PALETTE_SIZE);
    rec_pen_ok = {1'b0, ring_rdata.pen} < 9'(pur_pkg::PALETTE_SIZE);
    pdat       = pen_ok ? pal_rdata : '0;
    color_m    = pur_pkg::COLOR_BITS'(color);
    head_inc   = (head == pur_pkg::RING_AW'(pur_pkg::RING_DEPTH - 1)) ?
                 '0 : head + pur_pkg::RING_AW'(1);
    head_dec   = (head == '0) ?
                 pur_pkg::RING_AW'(pur_pkg::RING_DEPTH - 1) : head - pur_pkg::RING_AW'(1);
    len_inc    = (length < pur_pkg::LEN_CAP) ? length + 8'd1 : length;
    same_pen   = tracked_pen == {1'b0, pen};
    do_push    = 1'b0;
    push_rec   = '{pen: pen, color: tracked_color, linked: 1'b0};
    case (op)
      pur_pkg::FN_PUSH: begin
        do_push  = 1'b1;
        push_rec = '{pen: pen, color: (use_given ? color_m : pdat), linked: lk};
      end
      pur_pkg::FN_STORE: begin
        do_push = same_pen && (pdat != tracked_color) && !tracked_saved;
      end
      default: begin
        do_push = 1'b0;
      end
    endcase
  end

  // Memory requests and result word per state
  always_comb begin
    in_ready       = 1'b0;
    res_valid      = 1'b0;
    pal_req        = '0;
    pal_req.raddr  = in_item.pen[pur_pkg::PAL_AW-1:0];
    ring_req       = '0;
    ring_req.waddr = head;
    ring_req.raddr = head_dec;
    ring_req.wrec  = push_rec;
    res_next       = '{restored: restored, undo_count: length, color_out: 24'd0,
                       notify: 1'b1};
    unique case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        pal_req.re = in_valid;
      end
      ST_EXEC: begin
        pal_req.we    = (op == pur_pkg::FN_WRITE) && pen_ok;
        pal_req.waddr = pen[pur_pkg::PAL_AW-1:0];
        pal_req.wdata = color_m;
        ring_req.we   = do_push;
        res_next.notify     = (op == pur_pkg::FN_STORE) && do_push;
        res_next.color_out  = (op == pur_pkg::FN_READ) ? 24'(pdat) : 24'd0;
        res_next.undo_count = do_push ? len_inc : length;
        res_next.restored   = 8'd0;
      end
      ST_UREQ: begin
        ring_req.re = length != 8'd0;
      end
      ST_UPOP: begin
        pal_req.we          = rec_pen_ok;
        pal_req.waddr       = ring_rdata.pen[pur_pkg::PAL_AW-1:0];
        pal_req.wdata       = ring_rdata.color;
        res_next.undo_count = length - 8'd1;
        res_next.restored   = restored + 8'd1;
      end
      ST_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign res = result;

  // Sequencer: state, tracking, ring pointers and result
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      tracked_pen   <= pur_pkg::PEN_NONE;
      tracked_color <= '0;
      tracked_saved <= 1'b0;
      head          <= '0;
      length        <= 8'd0;
      restored      <= 8'd0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            op        <= pur_pkg::func_t'(in_item.func);
            pen       <= in_item.pen;
            color     <= in_item.color;
            use_given <= in_item.use_given;
            lk        <= in_item.linked;
            if (in_item.func == pur_pkg::FN_UNDO) begin
              tracked_pen <= pur_pkg::PEN_NONE;
              restored    <= 8'd0;
              state       <= ST_UREQ;
            end else begin
              state <= ST_EXEC;
            end
          end
        end
        ST_EXEC: begin
          if (op == pur_pkg::FN_STORE) begin
            if (!same_pen) begin
              tracked_pen   <= {1'b0, pen};
              tracked_color <= pdat;
              tracked_saved <= 1'b0;
            end else if (do_push) begin
              tracked_saved <= 1'b1;
            end
          end
          if (do_push) begin
            head   <= head_inc;
            length <= len_inc;
          end
          result <= res_next;
          state  <= ST_DONE;
        end
        ST_UREQ: begin
          if (length == 8'd0) begin
            result <= res_next;
            state  <= ST_DONE;
          end else begin
            state <= ST_UPOP;
          end
        end
        ST_UPOP: begin
          head     <= head_dec;
          length   <= length - 8'd1;
          restored <= restored + 8'd1;
          if (ring_rdata.linked) begin
            state <= ST_UREQ;
          end else begin
            result <= res_next;
            state  <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_take) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
